@@ src/mrc_pkg.sv @@
// Shared constants, types and state encodings for the mixed-radix converter.
package mrc_pkg;

	// sizing
	localparam int MAX_OUT_DIGITS = 6;
	localparam int RADIX_LIMIT    = 50;
	localparam int ACC_WIDTH      = 40;

	// fixed field widths
	localparam int DIGIT_W    = 16;
	localparam int RADIX_W    = 6;
	localparam int CNT_W      = 3;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RADIX_W;

	// derived widths
	localparam int MUL_W  = ACC_WIDTH + DIGIT_W;
	localparam int PROD_W = RADIX_W * MAX_OUT_DIGITS;
	localparam int VAL_W  = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W;
	localparam int STEP_W = $clog2(VAL_W);
	localparam int IDX_W  = (MAX_OUT_DIGITS > 1) ? $clog2(MAX_OUT_DIGITS) : 1;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_RADIX_0 = 3'd1;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_BAD_RADIX = 2'd2,
		ST_TOO_BIG   = 2'd3
	} word_status_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_TERM,
		F_ADD,
		F_WGT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PROD,
		B_CHECK,
		B_ERR,
		B_DIV,
		B_EMIT
	} back_state_t;

	// finished number handed from front to back
	typedef struct packed {
		logic [ACC_WIDTH-1:0] acc;
		logic                 ovf;
		logic                 ierr;
	} job_t;

	typedef struct packed {
		logic [CNT_W-1:0]                        count;
		logic [MAX_OUT_DIGITS-1:0][RADIX_W-1:0] radix;
	} cfg_t;

endpackage

@@ src/mrc_front.sv @@
// Front end: takes input digits and builds the accumulated value and place weight.
module mrc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [mrc_pkg::DIGIT_W-1:0] in_digit,
	input  logic [mrc_pkg::DIGIT_W-1:0] in_radix,
	input  logic                       last_digit,
	output logic                       push,
	output mrc_pkg::job_t              push_job,
	input  logic                       q_full
);
	import mrc_pkg::*;

	front_state_t         state_q, state_d;
	logic [DIGIT_W-1:0]   digit_q, radix_q;
	logic                 last_q;
	logic [ACC_WIDTH-1:0] acc_q, pw_q;
	logic                 ierr_q, ovf_q, wsat_q;
	logic [MUL_W-1:0]     prod_q;
	logic [DIGIT_W-1:0]   mul_b;
	logic                 accept;
	logic                 prod_hi;
	logic [ACC_WIDTH:0]   sum;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (in_valid) state_d = F_TERM;
			F_TERM: state_d = F_ADD;
			F_ADD:  state_d = F_WGT;
			F_WGT:  state_d = last_q ? F_PUSH : F_IDLE;
			F_PUSH: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		push     = 1'b0;
		mul_b    = radix_q;
		case (state_q)
			F_IDLE: in_stall = 1'b0;
			F_TERM: mul_b = digit_q;
			F_PUSH: push = !q_full;
			default: ;
		endcase
	end

	assign accept   = in_valid && !in_stall;
	assign prod_hi  = |prod_q[MUL_W-1:ACC_WIDTH];
	assign sum      = {1'b0, acc_q} + {1'b0, prod_q[ACC_WIDTH-1:0]};
	assign push_job = '{acc: acc_q, ovf: ovf_q, ierr: ierr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// one shared multiplier: term in F_TERM, next weight in F_ADD
	always_ff @(posedge clk) begin
		prod_q <= {{DIGIT_W{1'b0}}, pw_q} * {{ACC_WIDTH{1'b0}}, mul_b};
		if (accept) begin
			digit_q <= in_digit;
			radix_q <= in_radix;
			last_q  <= last_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pw_q   <= ACC_WIDTH'(1);
			ierr_q <= 1'b0;
			ovf_q  <= 1'b0;
			wsat_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && in_digit >= in_radix) ierr_q <= 1'b1;
				end
				F_ADD: begin
					// saturate once the term or the sum leaves the accumulator
					if (digit_q != '0 && !ovf_q) begin
						if (wsat_q || prod_hi || sum[ACC_WIDTH]) begin
							ovf_q <= 1'b1;
							acc_q <= '1;
						end else begin
							acc_q <= sum[ACC_WIDTH-1:0];
						end
					end
				end
				F_WGT: begin
					if (radix_q == '0) begin
						pw_q   <= '0;
						wsat_q <= 1'b0;
					end else if (!wsat_q) begin
						if (prod_hi) begin
							pw_q   <= '1;
							wsat_q <= 1'b1;
						end else begin
							pw_q <= prod_q[ACC_WIDTH-1:0];
						end
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						acc_q  <= '0;
						pw_q   <= ACC_WIDTH'(1);
						ierr_q <= 1'b0;
						ovf_q  <= 1'b0;
						wsat_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_wsat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		wsat_q |-> pw_q == '1)
		else $error("saturated weight not all ones");
	a_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> last_q)
		else $error("job pushed for a digit not marked last");
`endif

endmodule

@@ src/mrc_queue.sv @@
// Short job queue between the front end and the conversion back end.
module mrc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mrc_pkg::job_t push_job,
	input  logic          pop,
	output mrc_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);
	import mrc_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");
`endif

endmodule

@@ src/mrc_back.sv @@
// Back end: range checks, radix product, digit division and result output register.
module mrc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mrc_pkg::cfg_t               cfg,
	input  mrc_pkg::job_t               job,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mrc_pkg::RADIX_W-1:0] out_digit,
	output logic [mrc_pkg::CNT_W-1:0]   out_position,
	output logic [mrc_pkg::ST_W-1:0]    status,
	output logic                        last
);
	import mrc_pkg::*;

	back_state_t         state_q, state_d;
	job_t                job_q;
	logic [CNT_W-1:0]    n_q, idx_q, n_cfg;
	logic [PROD_W-1:0]   prod_q;
	logic [VAL_W-1:0]    val_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [STEP_W-1:0]   step_q;
	logic [RADIX_W-1:0]  dig_q [MAX_OUT_DIGITS];
	word_status_t        err_q, status_chk;
	logic [RADIX_W-1:0]  radix_sel;
	logic                bad_radix;
	logic [RADIX_W:0]    rs, rem_nx;
	logic                ge, div_last, out_free, out_load;
	logic                out_valid_q, last_q;
	logic [RADIX_W-1:0]  out_digit_q;
	logic [CNT_W-1:0]    out_position_q;
	logic [ST_W-1:0]     status_q;

	assign n_cfg     = (cfg.count > CNT_W'(MAX_OUT_DIGITS)) ? CNT_W'(MAX_OUT_DIGITS) : cfg.count;
	assign radix_sel = cfg.radix[idx_q[IDX_W-1:0]];

	always_comb begin
		bad_radix = (n_q == '0);
		for (int i = 0; i < MAX_OUT_DIGITS; i++) begin
			if (CNT_W'(i) < n_q && (cfg.radix[i] == '0 ||
			    {1'b0, cfg.radix[i]} >= (RADIX_W+1)'(RADIX_LIMIT)))
				bad_radix = 1'b1;
		end
	end

	always_comb begin
		if (bad_radix)
			status_chk = ST_BAD_RADIX;
		else if (job_q.ierr)
			status_chk = ST_BAD_DIGIT;
		else if (job_q.ovf || VAL_W'(job_q.acc) >= VAL_W'(prod_q))
			status_chk = ST_TOO_BIG;
		else
			status_chk = ST_OK;
	end

	// restoring division, one quotient bit per cycle
	assign rs       = {rem_q, val_q[VAL_W-1]};
	assign ge       = rs >= {1'b0, radix_sel};
	assign rem_nx   = ge ? rs - {1'b0, radix_sel} : rs;
	assign div_last = step_q == STEP_W'(VAL_W - 1);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!q_empty) state_d = B_PROD;
			B_PROD:  if (idx_q == n_q) state_d = B_CHECK;
			B_CHECK: state_d = (status_chk != ST_OK) ? B_ERR : B_DIV;
			B_ERR:   if (out_free) state_d = B_IDLE;
			B_DIV:   if (div_last && idx_q == n_q - CNT_W'(1)) state_d = B_EMIT;
			B_EMIT:  if (out_free && idx_q == '0) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE:  pop = !q_empty;
			B_ERR:   out_load = out_free;
			B_EMIT:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			step_q      <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						n_q   <= n_cfg;
						idx_q <= '0;
					end
				end
				B_PROD:  if (idx_q != n_q) idx_q <= idx_q + CNT_W'(1);
				B_CHECK: begin
					idx_q  <= '0;
					step_q <= '0;
				end
				B_DIV: begin
					if (div_last) begin
						step_q <= '0;
						if (idx_q != n_q - CNT_W'(1)) idx_q <= idx_q + CNT_W'(1);
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				B_EMIT:  if (out_free && idx_q != '0) idx_q <= idx_q - CNT_W'(1);
				default: ;
			endcase
			if (out_load)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					job_q  <= job;
					prod_q <= PROD_W'(1);
				end
			end
			B_PROD: begin
				if (idx_q != n_q)
					prod_q <= PROD_W'(prod_q * {{(PROD_W-RADIX_W){1'b0}}, radix_sel});
			end
			B_CHECK: begin
				err_q <= status_chk;
				val_q <= VAL_W'(job_q.acc);
				rem_q <= '0;
			end
			B_DIV: begin
				val_q <= {val_q[VAL_W-2:0], ge};
				if (div_last) begin
					rem_q                    <= '0;
					dig_q[idx_q[IDX_W-1:0]] <= rem_nx[RADIX_W-1:0];
				end else begin
					rem_q <= rem_nx[RADIX_W-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			if (state_q == B_ERR) begin
				out_digit_q    <= '0;
				out_position_q <= '0;
				status_q       <= err_q;
				last_q         <= 1'b1;
			end else begin
				out_digit_q    <= dig_q[idx_q[IDX_W-1:0]];
				out_position_q <= idx_q;
				status_q       <= ST_OK;
				last_q         <= idx_q == '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_digit    = out_digit_q;
	assign out_position = out_position_q;
	assign status       = status_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && out_digit == '0)
		else $error("error word not a lone final word");
	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> idx_q < n_q)
		else $error("division digit index beyond digit count");
`endif

endmodule

@@ src/mixed_radix_converter.sv @@
// Top level of the mixed-radix converter: configuration registers, front end, queue, back end.
//
// Input digits arrive least significant first, each word carrying its own radix; the front end
// folds each one into a 40-bit accumulator (sum += weight*digit, weight *= radix) using a single
// shared multiplier, stepping through term, add and weight states for each digit and a push
// state on the last digit to hand the finished number to a 2-deep job queue. The back end then
// takes each number from the queue, forms the product of the n output radices in use and checks
// them, then, if all is well, runs n restoring divisions by the output radices at one quotient
// bit per cycle, then sends the digits most significant first. An error (bad output radix,
// a digit not below its radix, or a value too big for the output radices) gives a single word
// with last set. The divider sets the throughput for whole conversions; the queue lets the front
// end take the next number's digits while the back end is still converting. Output words are
// held in an output register until taken, so the back end does not wait on a stalled consumer
// for the word it is forming. Configuration is written through cfg_valid/cfg_ready (always
// ready): index 0 is the output digit count, indexes 1 to 6 the output radices, index 7 is
// ignored; write only while the block is idle.
module mixed_radix_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mrc_pkg::DIGIT_W-1:0]    in_digit,
	input  logic [mrc_pkg::DIGIT_W-1:0]    in_radix,
	input  logic                           last_digit,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mrc_pkg::RADIX_W-1:0]    out_digit,
	output logic [mrc_pkg::CNT_W-1:0]      out_position,
	output logic [mrc_pkg::ST_W-1:0]       status,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mrc_pkg::*;

	cfg_t                 cfg_q;
	logic [CFG_IDX_W-1:0] radix_slot;
	logic                 push, pop, q_full, q_empty;
	job_t                 push_job, pop_job;

	// configuration registers; always ready
	assign cfg_ready  = 1'b1;
	assign radix_slot = cfg_index - CFG_OUT_RADIX_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count <= CNT_W'(1);
			cfg_q.radix <= {MAX_OUT_DIGITS{RADIX_W'(1)}};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OUT_COUNT: cfg_q.count <= cfg_data[CNT_W-1:0];
				default: begin
					// indexes past the last radix are dropped
					if (radix_slot < CFG_IDX_W'(MAX_OUT_DIGITS))
						cfg_q.radix[radix_slot[IDX_W-1:0]] <= cfg_data[RADIX_W-1:0];
				end
			endcase
		end
	end

	mrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_digit   (in_digit),
		.in_radix   (in_radix),
		.last_digit (last_digit),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	mrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	mrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.job          (pop_job),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_digit    (out_digit),
		.out_position (out_position),
		.status       (status),
		.last         (last)
	);

endmodule
